// ----- src/lqm_pkg.sv -----
package lqm_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int DIAG_W          = 16;
  localparam int QUAL_W          = 7;
  localparam int UPTIME_W        = 24;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 8;
  localparam int MEDIA_W         = 3;
  localparam int INTERVAL_W      = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_MEDIA_KIND      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_INTERVAL = 2'd1;

  localparam logic [MEDIA_W-1:0] MEDIA_TP    = 3'd0;
  localparam logic [MEDIA_W-1:0] MEDIA_COAX  = 3'd1;
  localparam logic [MEDIA_W-1:0] MEDIA_AUI   = 3'd2;
  localparam logic [MEDIA_W-1:0] MEDIA_FIBER = 3'd3;

  localparam int BIT_LINK_BEAT = 11;
  localparam int BIT_SQE_TEST  = 9;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd1;
  localparam logic [QUAL_W-1:0]     STABLE_LIMIT   = 7'd80;
  localparam logic [QUAL_W-1:0]     PASS_LIMIT     = 7'd50;

  typedef struct packed {
    logic [DIAG_W-1:0] diag_word;
    logic              last_sample;
  } lqm_in_t;

  typedef struct packed {
    logic [QUAL_W-1:0]   quality_percent;
    logic                link_up_seen;
    logic                carrier_seen;
    logic                sqe_passed;
    logic                link_stable;
    logic                test_pass;
    logic [15:0]         up_samples;
    logic [15:0]         total_samples;
    logic [UPTIME_W-1:0] up_time_ms;
    logic [DIAG_W-1:0]   final_diag;
  } lqm_out_t;

  typedef struct packed {
    logic link;
    logic carrier;
    logic sqe;
  } lqm_flags_t;

  typedef enum logic {
    ST_IDLE,
    ST_CALC
  } lqm_state_t;

endpackage

// ----- src/lqm_accum.sv -----
module lqm_accum #(
  parameter int COUNT_WIDTH = lqm_pkg::COUNT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        sample_en,
  input  logic [lqm_pkg::DIAG_W-1:0]  diag_word,
  input  logic                        last_sample,
  input  logic [lqm_pkg::MEDIA_W-1:0] media_kind,
  output logic [COUNT_WIDTH-1:0]      up_cnt_nxt,
  output logic [COUNT_WIDTH-1:0]      total_cnt_nxt,
  output lqm_pkg::lqm_flags_t         flags_nxt
);

  logic [COUNT_WIDTH-1:0] up_cnt_r;
  logic [COUNT_WIDTH-1:0] total_cnt_r;
  lqm_pkg::lqm_flags_t    flags_r;
  logic                   is_up;

  always_comb begin
    is_up     = 1'b0;
    flags_nxt = flags_r;
    case (media_kind)
      lqm_pkg::MEDIA_TP, lqm_pkg::MEDIA_FIBER: begin
        if (diag_word[lqm_pkg::BIT_LINK_BEAT]) begin
          is_up          = 1'b1;
          flags_nxt.link = 1'b1;
        end
      end
      lqm_pkg::MEDIA_COAX: begin
        is_up             = 1'b1;
        flags_nxt.carrier = 1'b1;
      end
      lqm_pkg::MEDIA_AUI: begin
        if (diag_word[lqm_pkg::BIT_SQE_TEST]) begin
          is_up         = 1'b1;
          flags_nxt.sqe = 1'b1;
        end
      end
      default: ;
    endcase
    // counters stop at all ones
    up_cnt_nxt    = (is_up && !(&up_cnt_r)) ? up_cnt_r + 1'b1 : up_cnt_r;
    total_cnt_nxt = (&total_cnt_r) ? total_cnt_r : total_cnt_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_cnt_r    <= '0;
      total_cnt_r <= '0;
      flags_r     <= '0;
    end else if (sample_en) begin
      if (last_sample) begin
        up_cnt_r    <= '0;
        total_cnt_r <= '0;
        flags_r     <= '0;
      end else begin
        up_cnt_r    <= up_cnt_nxt;
        total_cnt_r <= total_cnt_nxt;
        flags_r     <= flags_nxt;
      end
    end
  end

endmodule

// ----- src/lqm_calc.sv -----
module lqm_calc #(
  parameter int COUNT_WIDTH = lqm_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           ack,
  input  logic [COUNT_WIDTH-1:0]         up_cnt,
  input  logic [COUNT_WIDTH-1:0]         total_cnt,
  input  logic [lqm_pkg::INTERVAL_W-1:0] interval,
  output logic                           done,
  output logic [lqm_pkg::QUAL_W-1:0]     quality,
  output logic [lqm_pkg::UPTIME_W-1:0]   up_time
);

  localparam int NW = COUNT_WIDTH + lqm_pkg::QUAL_W;     // up * 100
  localparam int PW = COUNT_WIDTH + lqm_pkg::INTERVAL_W; // up * interval
  localparam int EW = 40;

  logic                           busy_r;
  logic                           done_r;
  logic [2:0]                     step_r;
  logic [NW-1:0]                  rem_r;
  logic [NW-1:0]                  dsh_r;
  logic [lqm_pkg::QUAL_W-1:0]     quot_r;
  logic [PW-1:0]                  acc_r;
  logic [PW-1:0]                  mcand_r;
  logic [lqm_pkg::INTERVAL_W-1:0] mplier_r;
  logic [NW-1:0]                  up_x100;
  logic                           fits;
  logic [EW-1:0]                  acc_ext;

  // x * 100 = x*64 + x*32 + x*4
  assign up_x100 = (NW'(up_cnt) << 6) + (NW'(up_cnt) << 5) + (NW'(up_cnt) << 2);
  assign fits    = (rem_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      if (ack) begin
        done_r <= 1'b0;
      end
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == 3'd7) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // restoring divide, one quotient bit a cycle, quotient never above 100
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r    <= up_x100;
      dsh_r    <= NW'(total_cnt) << (lqm_pkg::QUAL_W - 1);
      quot_r   <= '0;
      acc_r    <= '0;
      mcand_r  <= PW'(up_cnt);
      mplier_r <= interval;
    end else if (busy_r) begin
      if (step_r != 3'd7) begin
        if (fits) begin
          rem_r <= rem_r - dsh_r;
        end
        quot_r <= {quot_r[lqm_pkg::QUAL_W-2:0], fits};
        dsh_r  <= dsh_r >> 1;
      end
      // shift-add multiply, one interval bit a cycle
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
    end
  end

  assign acc_ext = EW'(acc_r);
  assign done    = done_r;
  assign quality = quot_r;
  assign up_time = (acc_ext > EW'(24'hFFFFFF)) ? 24'hFFFFFF : acc_ext[lqm_pkg::UPTIME_W-1:0];

endmodule

// ----- src/link_quality_monitor.sv -----
// channel   direction  handshake              payload
// in_       input      in_valid / in_stall    lqm_in_t  (diag_word, last_sample)
// out_      output     out_valid / out_stall  lqm_out_t (verdicts, counts, up time, diag)
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// ordinary samples are taken without a stall; a last sample raises in_stall while the
// serial divide/multiply unit runs and until its result is registered
// reset clears the counters, sticky flags and output valid, and restores the
// registers to twisted pair and a 1 ms interval; cfg_ready is always high
// samples keep being taken while a result waits under out_stall; after a further
// last sample in_stall stays high until the output register frees up
module link_quality_monitor #(
  parameter int COUNT_WIDTH = lqm_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lqm_pkg::lqm_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lqm_pkg::lqm_out_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lqm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lqm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  lqm_pkg::lqm_state_t            state_r, state_nxt;
  logic [lqm_pkg::MEDIA_W-1:0]    media_r;
  logic [lqm_pkg::INTERVAL_W-1:0] interval_r;
  logic                           in_xfer;
  logic                           win_end;
  logic                           load_out;
  logic                           out_free;
  logic [COUNT_WIDTH-1:0]         up_cnt_nxt;
  logic [COUNT_WIDTH-1:0]         total_cnt_nxt;
  lqm_pkg::lqm_flags_t            flags_nxt;
  logic [COUNT_WIDTH-1:0]         up_hold_r;
  logic [COUNT_WIDTH-1:0]         total_hold_r;
  lqm_pkg::lqm_flags_t            flags_hold_r;
  logic [lqm_pkg::DIAG_W-1:0]     diag_hold_r;
  logic                           calc_done;
  logic [lqm_pkg::QUAL_W-1:0]     quality;
  logic [lqm_pkg::UPTIME_W-1:0]   up_time;
  logic                           out_valid_r, out_valid_nxt;
  lqm_pkg::lqm_out_t              out_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != lqm_pkg::ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign win_end   = in_xfer && in_data.last_sample;
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      media_r    <= lqm_pkg::MEDIA_TP;
      interval_r <= lqm_pkg::INTERVAL_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == lqm_pkg::REG_MEDIA_KIND) begin
        media_r <= cfg_data[lqm_pkg::MEDIA_W-1:0];
      end else if (cfg_index == lqm_pkg::REG_SAMPLE_INTERVAL) begin
        interval_r <= cfg_data[lqm_pkg::INTERVAL_W-1:0];
      end
    end
  end

  lqm_accum #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_accum (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_en    (in_xfer),
    .diag_word    (in_data.diag_word),
    .last_sample  (in_data.last_sample),
    .media_kind   (media_r),
    .up_cnt_nxt   (up_cnt_nxt),
    .total_cnt_nxt(total_cnt_nxt),
    .flags_nxt    (flags_nxt)
  );

  lqm_calc #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_calc (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (win_end),
    .ack      (load_out),
    .up_cnt   (up_cnt_nxt),
    .total_cnt(total_cnt_nxt),
    .interval (interval_r),
    .done     (calc_done),
    .quality  (quality),
    .up_time  (up_time)
  );

  // window snapshot kept for the result while the serial unit runs
  always_ff @(posedge clk) begin
    if (win_end) begin
      up_hold_r    <= up_cnt_nxt;
      total_hold_r <= total_cnt_nxt;
      flags_hold_r <= flags_nxt;
      diag_hold_r  <= in_data.diag_word;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      lqm_pkg::ST_IDLE: begin
        if (win_end) begin
          state_nxt = lqm_pkg::ST_CALC;
        end
      end
      lqm_pkg::ST_CALC: begin
        if (calc_done && out_free) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = lqm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lqm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lqm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r.quality_percent <= quality;
      out_r.link_up_seen    <= flags_hold_r.link;
      out_r.carrier_seen    <= flags_hold_r.carrier;
      out_r.sqe_passed      <= flags_hold_r.sqe;
      out_r.link_stable     <= (quality > lqm_pkg::STABLE_LIMIT);
      out_r.test_pass       <= (quality > lqm_pkg::PASS_LIMIT);
      out_r.up_samples      <= 16'(up_hold_r);
      out_r.total_samples   <= 16'(total_hold_r);
      out_r.up_time_ms      <= up_time;
      out_r.final_diag      <= diag_hold_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- test/link_quality_monitor_test.sv -----
`timescale 1ns / 100ps

// works out the report of each test window and checks the block's reports in order
class lqm_window_judge;
  logic [lqm_pkg::MEDIA_W-1:0]         media;
  logic [lqm_pkg::INTERVAL_W-1:0]      interval_ms;
  logic [lqm_pkg::COUNT_WIDTH_DEF-1:0] up_count;
  logic [lqm_pkg::COUNT_WIDTH_DEF-1:0] sample_count;
  lqm_pkg::lqm_flags_t                 seen;
  lqm_pkg::lqm_out_t                   pending_reports[$];
  int unsigned                         mismatches;
  int unsigned                         reports_checked;
  int unsigned                         samples_taken;

  function new();
    media           = lqm_pkg::MEDIA_TP;
    interval_ms     = lqm_pkg::INTERVAL_RESET;
    up_count        = '0;
    sample_count    = '0;
    seen            = '0;
    mismatches      = 0;
    reports_checked = 0;
    samples_taken   = 0;
  endfunction

  function void apply_register(logic [lqm_pkg::CFG_INDEX_W-1:0] idx,
                               logic [lqm_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      lqm_pkg::REG_MEDIA_KIND:      media = data[lqm_pkg::MEDIA_W-1:0];
      lqm_pkg::REG_SAMPLE_INTERVAL: interval_ms = data[lqm_pkg::INTERVAL_W-1:0];
      default: ;
    endcase
  endfunction

  function void take_sample(lqm_pkg::lqm_in_t s);
    logic              up;
    int unsigned       pct;
    int unsigned       up_time;
    lqm_pkg::lqm_out_t r;
    up = 1'b0;
    case (media)
      lqm_pkg::MEDIA_TP, lqm_pkg::MEDIA_FIBER: begin
        if (s.diag_word[lqm_pkg::BIT_LINK_BEAT]) begin
          up = 1'b1;
          seen.link = 1'b1;
        end
      end
      lqm_pkg::MEDIA_COAX: begin
        up = 1'b1;
        seen.carrier = 1'b1;
      end
      lqm_pkg::MEDIA_AUI: begin
        if (s.diag_word[lqm_pkg::BIT_SQE_TEST]) begin
          up = 1'b1;
          seen.sqe = 1'b1;
        end
      end
      default: ;
    endcase
    // both counters stick at all ones
    if (up && up_count != '1) up_count++;
    if (sample_count != '1) sample_count++;
    samples_taken++;
    if (!s.last_sample) return;

    pct = (int'(up_count) * 100) / int'(sample_count);
    if (pct > 100) pct = 100;
    up_time = int'(up_count) * int'(interval_ms);
    if (up_time > 32'h00FF_FFFF) up_time = 32'h00FF_FFFF;

    r.quality_percent = pct[lqm_pkg::QUAL_W-1:0];
    r.link_up_seen    = seen.link;
    r.carrier_seen    = seen.carrier;
    r.sqe_passed      = seen.sqe;
    r.link_stable     = pct > lqm_pkg::STABLE_LIMIT;
    r.test_pass       = pct > lqm_pkg::PASS_LIMIT;
    r.up_samples      = up_count[15:0];
    r.total_samples   = sample_count[15:0];
    r.up_time_ms      = up_time[lqm_pkg::UPTIME_W-1:0];
    r.final_diag      = s.diag_word;
    pending_reports.push_back(r);

    up_count     = '0;
    sample_count = '0;
    seen         = '0;
  endfunction

  function void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function void check_report(lqm_pkg::lqm_out_t got);
    lqm_pkg::lqm_out_t want;
    if (pending_reports.size() == 0) begin
      $display("%0t: report with no window closed, actual %p", $time, got);
      mismatches++;
      return;
    end
    want = pending_reports.pop_front();
    reports_checked++;
    check_field("quality_percent", 32'(want.quality_percent), 32'(got.quality_percent));
    check_field("link_up_seen", 32'(want.link_up_seen), 32'(got.link_up_seen));
    check_field("carrier_seen", 32'(want.carrier_seen), 32'(got.carrier_seen));
    check_field("sqe_passed", 32'(want.sqe_passed), 32'(got.sqe_passed));
    check_field("link_stable", 32'(want.link_stable), 32'(got.link_stable));
    check_field("test_pass", 32'(want.test_pass), 32'(got.test_pass));
    check_field("up_samples", 32'(want.up_samples), 32'(got.up_samples));
    check_field("total_samples", 32'(want.total_samples), 32'(got.total_samples));
    check_field("up_time_ms", 32'(want.up_time_ms), 32'(got.up_time_ms));
    check_field("final_diag", 32'(want.final_diag), 32'(got.final_diag));
  endfunction
endclass

module link_quality_monitor_test;

  localparam logic [lqm_pkg::CFG_INDEX_W-1:0] REG_UNUSED_LO = 2'd2;
  localparam logic [lqm_pkg::CFG_INDEX_W-1:0] REG_UNUSED_HI = 2'd3;
  localparam logic [lqm_pkg::MEDIA_W-1:0]     MEDIA_NONE_LO = 3'd4;
  localparam logic [lqm_pkg::MEDIA_W-1:0]     MEDIA_NONE_HI = 3'd7;
  localparam int SETTLE_CYCLES = 12;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  lqm_pkg::lqm_in_t                in_data;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  lqm_pkg::lqm_out_t               out_data;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [lqm_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [lqm_pkg::CFG_DATA_W-1:0]  cfg_data;

  lqm_window_judge judge;
  int unsigned     burst_left = 0;
  bit              gaps_on = 1'b1;
  int unsigned     stall_left = 0;
  int unsigned     free_left = 0;

  link_quality_monitor i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[link_quality_monitor] ERROR");
    $finish;
  end

  // receiver: free stretches, some of them long, broken by stall runs
  always @(posedge clk) begin
    if (free_left != 0) begin
      free_left <= free_left - 1;
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      free_left  <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(0, 20);
      stall_left <= $urandom_range(1, 14);
      out_stall  <= 1'b0;
    end
  end

  // every transfer on the three channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) judge.apply_register(cfg_index, cfg_data);
      if (in_valid && !in_stall) judge.take_sample(in_data);
      if (out_valid && !out_stall) judge.check_report(out_data);
    end
  end

  task automatic program_register(input logic [lqm_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [lqm_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_media_interval(input logic [lqm_pkg::CFG_DATA_W-1:0] media_data,
                                    input logic [lqm_pkg::CFG_DATA_W-1:0] interval_data);
    program_register(lqm_pkg::REG_MEDIA_KIND, media_data);
    program_register(lqm_pkg::REG_SAMPLE_INTERVAL, interval_data);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sample(input logic [lqm_pkg::DIAG_W-1:0] diag, input logic last);
    in_valid <= 1'b1;
    in_data  <= '{diag_word: diag, last_sample: last};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic offer_sample(input logic [lqm_pkg::DIAG_W-1:0] diag, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 10) : 0;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    send_sample(diag, last);
  endtask

  task automatic wait_reports_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (judge.pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned                     random_goal;
    int unsigned                     phase_items;
    int unsigned                     phase_count;
    int unsigned                     win_len;
    int unsigned                     up_pct;
    int unsigned                     pick;
    logic [lqm_pkg::MEDIA_W-1:0]     media_sel;
    logic [7:0]                      interval_sel;
    logic [lqm_pkg::DIAG_W-1:0]      diag;

    judge     = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // twisted pair at reset: full, empty, quality of exactly 80 and exactly 50
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0000, 1'b1);
    repeat (4) send_sample(16'h0800, 1'b0);
    send_sample(16'hF7FF, 1'b1);
    send_sample(16'h0800, 1'b0);
    send_sample(16'hF7FF, 1'b0);
    send_sample(16'h0800, 1'b0);
    send_sample(16'hF7FF, 1'b1);

    wait_reports_done();
    set_media_interval({5'd0, lqm_pkg::MEDIA_COAX}, 8'd255);
    send_sample(16'h0000, 1'b1);

    // zero interval gives no up time
    wait_reports_done();
    set_media_interval({5'd0, lqm_pkg::MEDIA_AUI}, 8'd0);
    send_sample(16'h0200, 1'b0);
    send_sample(16'hFDFF, 1'b1);

    wait_reports_done();
    set_media_interval({5'd0, lqm_pkg::MEDIA_FIBER}, 8'h80);
    send_sample(16'h0800, 1'b0);
    send_sample(16'h0800, 1'b0);
    send_sample(16'h0000, 1'b1);

    // unsupported media never counts as up
    wait_reports_done();
    program_register(lqm_pkg::REG_MEDIA_KIND, 8'hFF);
    cfg_valid <= 1'b0;
    @(posedge clk);
    send_sample(16'hFFFF, 1'b1);

    // unknown indexes leave both registers alone
    wait_reports_done();
    program_register(REG_UNUSED_LO, 8'h01);
    program_register(REG_UNUSED_HI, 8'hFF);
    cfg_valid <= 1'b0;
    @(posedge clk);
    send_sample(16'h0A00, 1'b1);

    wait_reports_done();
    program_register(lqm_pkg::REG_MEDIA_KIND, {5'd0, MEDIA_NONE_LO});
    cfg_valid <= 1'b0;
    @(posedge clk);
    send_sample(16'hFFFF, 1'b1);

    random_goal = 1700;
    while (judge.samples_taken < random_goal) begin
      wait_reports_done();
      media_sel = ($urandom_range(0, 4) == 0)
                  ? 3'($urandom_range(MEDIA_NONE_LO, MEDIA_NONE_HI))
                  : 3'($urandom_range(lqm_pkg::MEDIA_TP, lqm_pkg::MEDIA_FIBER));
      pick = $urandom_range(0, 9);
      interval_sel = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom);
      set_media_interval({5'($urandom), media_sel}, interval_sel);
      gaps_on     = ($urandom_range(0, 3) != 0);
      phase_items = $urandom_range(60, 220);
      phase_count = 0;
      while (phase_count < phase_items && judge.samples_taken < random_goal) begin
        win_len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        up_pct  = $urandom_range(0, 100);
        for (int unsigned i = 0; i < win_len; i++) begin
          diag = 16'($urandom);
          diag[lqm_pkg::BIT_LINK_BEAT] = ($urandom_range(0, 99) < up_pct);
          diag[lqm_pkg::BIT_SQE_TEST]  = ($urandom_range(0, 99) < up_pct);
          offer_sample(diag, i == win_len - 1);
        end
        phase_count += win_len;
        // hold off now and then until the block has caught up
        if ($urandom_range(0, 19) == 0) wait_reports_done();
      end
    end

    wait_reports_done();
    $display("covered %0d samples: all eight media codes, intervals from 0 to 255,",
             judge.samples_taken);
    $display("quality on both verdict limits; %0d reports compared",
             judge.reports_checked);
    if (judge.mismatches == 0) begin
      $display("[link_quality_monitor] OK");
    end else begin
      $display("[link_quality_monitor] ERROR");
    end
    $finish;
  end

endmodule
